@@ rtl/mrts_pkg.sv @@
// Package for the memory range table sorter: constants, channel payload types and the
// command and status structs that join controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mrts_pkg;

  // Default table depth. The top level takes it as the parameter default.
  localparam int MAX_RECORDS_DEF = 32;

  // One input item: a memory-range record and the end-of-set marker.
  typedef struct packed {
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [31:0] range_type;
    logic [31:0] range_flags;
    logic        last_entry;
  } in_item_t;

  // One result item: a record at its sorted position.
  typedef struct packed {
    logic [63:0] sorted_start;
    logic [63:0] sorted_end;
    logic [31:0] sorted_type;
    logic [31:0] sorted_flags;
    logic        final_record;
    logic        table_overflow;
  } out_item_t;

  // Record as held in the table.
  typedef struct packed {
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [31:0] range_type;
    logic [31:0] range_flags;
  } rec_t;

  // Controller to datapath.
  typedef struct packed {
    logic mem_we;         // write the table
    logic wr_pos_rec;     // write data is the held position record, else the input record
    logic mem_re;         // read the table
    logic ld_pos;         // capture the read record as position and best record
    logic scan;           // compare the read record against the best so far
    logic emit;           // load the best record into the output register
    logic final_record;
    logic table_overflow;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic less;           // read start is strictly below the best start
    logic out_free;       // output register can take a record this cycle
  } stat_t;

endpackage

@@ rtl/mrts_stream_if.sv @@
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with the item types of mrts_pkg.
`timescale 1ns / 1ps

interface mrts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mrts_ctrl.sv @@
// Controller of the range table sorter: load, selection-sort scan and emit sequencing.
// Holds all counters and indices. Depends on mrts_pkg.
`timescale 1ns / 1ps

module mrts_ctrl import mrts_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output cmd_t             cmd,
  input  stat_t            stat,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] wr_addr
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDPOS = 3'd1;
  localparam logic [2:0] S_LDPOS = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] n_last;
  logic             accept;

  assign pos_inc = pos_r + CNT_ONE;
  assign idx_inc = idx_r + CNT_ONE;
  assign n_last  = n_r - CNT_ONE;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    cmd       = '0;
    rd_addr   = pos_r[IDX_W-1:0];
    wr_addr   = count_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (count_r < CNT_MAX) begin
            cmd.mem_we = 1'b1;
            count_nxt  = count_r + CNT_ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt     = (count_r < CNT_MAX) ? count_r + CNT_ONE : count_r;
            pos_nxt   = '0;
            state_nxt = S_RDPOS;
          end
        end
      end
      S_RDPOS: begin
        cmd.mem_re = 1'b1;
        rd_addr    = pos_r[IDX_W-1:0];
        state_nxt  = S_LDPOS;
      end
      S_LDPOS: begin
        cmd.ld_pos = 1'b1;
        best_nxt   = pos_r;
        if (pos_inc < n_r) begin
          cmd.mem_re = 1'b1;
          rd_addr    = pos_inc[IDX_W-1:0];
          idx_nxt    = pos_inc;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.less) begin
          best_nxt = idx_r;
        end
        if (idx_r == n_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.mem_re = 1'b1;
          rd_addr    = idx_inc[IDX_W-1:0];
          idx_nxt    = idx_inc;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit           = 1'b1;
          cmd.final_record   = (pos_r == n_last);
          cmd.table_overflow = ovf_r;
          // The record displaced from this position moves to where the minimum was.
          cmd.mem_we         = 1'b1;
          cmd.wr_pos_rec     = 1'b1;
          wr_addr            = best_r[IDX_W-1:0];
          if (pos_r == n_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_inc;
            state_nxt = S_RDPOS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("record count beyond table depth");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("record emitted into an occupied output register");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.final_record) |=> (count_r == '0 && !ovf_r && state_r == S_IDLE))
    else $error("table not emptied after the final record");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < n_r && idx_r > pos_r && best_r < n_r))
    else $error("scan index outside the stored records");

endmodule

@@ rtl/mrts_datapath.sv @@
// Datapath of the range table sorter: record table memory, position and best-record
// registers, start-address compare and the output register. Depends on mrts_pkg.
`timescale 1ns / 1ps

module mrts_datapath import mrts_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  mrts_stream_if.source     out_ch
);

  rec_t      mem [MAX_RECORDS];
  rec_t      rd_data_r;
  rec_t      pos_rec_r;
  rec_t      best_rec_r;
  rec_t      in_rec;
  rec_t      wr_data;
  out_item_t out_data_r;
  logic      out_valid_r;

  assign in_rec.range_start = in_item.range_start;
  assign in_rec.range_end   = in_item.range_end;
  assign in_rec.range_type  = in_item.range_type;
  assign in_rec.range_flags = in_item.range_flags;

  assign wr_data = cmd.wr_pos_rec ? pos_rec_r : in_rec;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign stat.less     = (rd_data_r.range_start < best_rec_r.range_start);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.ld_pos) begin
      pos_rec_r  <= rd_data_r;
      best_rec_r <= rd_data_r;
    end else if (cmd.scan && stat.less) begin
      best_rec_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.sorted_start   <= best_rec_r.range_start;
      out_data_r.sorted_end     <= best_rec_r.range_end;
      out_data_r.sorted_type    <= best_rec_r.range_type;
      out_data_r.sorted_flags   <= best_rec_r.range_flags;
      out_data_r.final_record   <= cmd.final_record;
      out_data_r.table_overflow <= cmd.table_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

@@ rtl/memory_range_table_sorter.sv @@
// Top level of the memory range table sorter: controller plus datapath.
// Depends on mrts_pkg, mrts_stream_if, mrts_ctrl and mrts_datapath.
//
//   Channel   Direction  Payload      Handshake
//   in_ch     sink       in_item_t    valid/ready, item taken when both high
//   out_ch    source     out_item_t   valid/ready, item taken when both high
//
// Records are taken one a cycle while the block is loading; an item without
// last_entry gives no result. An item with last_entry starts the sort of n stored
// records: each sorted position costs a read of that position, a step that loads it
// as the best so far, a scan of each remaining record and one emit step, an order
// set by the single read port of the record table and the one shared start compare.
// Reset is synchronous and active low; it empties the table and the output register.
// A stall on out_ch holds the block at the emit step; input is refused from the last
// item of a set until the final record has been loaded into the output register.
`timescale 1ns / 1ps

module memory_range_table_sorter import mrts_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mrts_stream_if.sink   in_ch,
  mrts_stream_if.source out_ch
);

  // Table index width, and counter width that can also hold the depth itself.
  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             in_ready;
  in_item_t         in_item;

  assign in_item     = in_ch.data;
  assign in_ch.ready = in_ready;

  // The controller sequences loading, the selection-sort scans and the emits;
  // it owns the record count, the sticky overflow flag and every table index.
  mrts_ctrl #(
    .MAX_RECORDS (MAX_RECORDS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_item.last_entry),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  // The datapath holds the table, the record at the current position, the
  // best record found so far, and the output register that decouples out_ch.
  mrts_datapath #(
    .MAX_RECORDS (MAX_RECORDS),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .stat    (stat),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .out_ch  (out_ch)
  );

endmodule
